>>> rtl/fhds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhds_pkg
// Shared widths, reset values, register map and the per-pixel control word of
// the heat diffusion stencil.
// ----------------------------------------------------------------------------
package fhds_pkg;

  localparam int HEAT_W      = 8;    // heat pixel width
  localparam int COL_W       = 7;    // reported column width
  localparam int ROW_W       = 8;    // reported row width
  localparam int ROW_CNT_W   = 9;    // internal row counter, holds the cap
  localparam int ROW_CAP     = 257;  // input rows counted before saturation
  localparam int MAX_WIDTH_DEF = 128;

  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  localparam logic [HEAT_W-1:0] ROW_WIDTH_RST = 8'd72;
  localparam logic [HEAT_W-1:0] DECAY_RST     = 8'd10;

  typedef enum logic [0:0] {
    REG_ROW_WIDTH = 1'b0,
    REG_DECAY     = 1'b1
  } reg_idx_e;

  // Control word that follows a pixel from the counter stage to the stencil.
  typedef struct packed {
    logic              emit;     // a new pixel is produced
    logic              prev_b;   // previous row lives in bank B
    logic              left_ok;  // left neighbor lies on the row
    logic              right_ok; // right neighbor lies on the row
    logic [HEAT_W-1:0] heat;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
  } pix_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/fhds_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhds_in_if / fhds_out_if
// Valid/ready channels that carry old heat pixels in and new pixels out.
// ----------------------------------------------------------------------------
interface fhds_in_if;
  import fhds_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [HEAT_W-1:0]        heat_in;
  logic                     frame_start;
  logic signed [1:0]        row_shift;

  modport source (output valid, heat_in, frame_start, row_shift, input ready);
  modport sink   (input valid, heat_in, frame_start, row_shift, output ready);
endinterface

interface fhds_out_if;
  import fhds_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [HEAT_W-1:0]        heat_out;
  logic [COL_W-1:0]         out_column;
  logic [ROW_W-1:0]         out_row;

  modport source (output valid, heat_out, out_column, out_row, input ready);
  modport sink   (input valid, heat_out, out_column, out_row, output ready);
endinterface
`default_nettype wire

>>> rtl/fhds_line_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhds_line_ram
// One line buffer bank: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
module fhds_line_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_l_i,
  input  wire logic [AW-1:0] raddr_r_i,
  output      logic [DW-1:0] rdata_l_o,
  output      logic [DW-1:0] rdata_r_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data only moves on an enabled read, so a stalled pixel keeps it.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_l_o <= mem[raddr_l_i];
      rdata_r_o <= mem[raddr_r_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/fhds_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhds_ctrl
// Column, row, bank and jitter tracking; line buffer addressing per pixel.
// ----------------------------------------------------------------------------
module fhds_ctrl #(
  parameter int MAX_WIDTH = 128,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     accept_i,
  input  wire logic [fhds_pkg::HEAT_W-1:0] heat_i,
  input  wire logic                     frame_start_i,
  input  wire logic [1:0]               row_shift_i,
  input  wire logic [fhds_pkg::HEAT_W-1:0] row_width_i,
  // Line buffer access.
  output      logic                     we_a_o,
  output      logic                     we_b_o,
  output      logic                     re_a_o,
  output      logic                     re_b_o,
  output      logic [AW-1:0]            waddr_o,
  output      logic [AW-1:0]            raddr_l_o,
  output      logic [AW-1:0]            raddr_r_o,
  output      fhds_pkg::pix_ctrl_t      pix_o
);
  import fhds_pkg::*;

  localparam int CntW = AW + 1;
  localparam int SW   = CntW + 1;

  logic [AW-1:0]        col_q;
  logic [ROW_CNT_W-1:0] row_q;
  logic                 sel_q;
  logic signed [1:0]    shift_q;

  logic [CntW-1:0]      width;
  logic [AW-1:0]        col0;
  logic [ROW_CNT_W-1:0] row0;
  logic                 sel0;
  logic signed [1:0]    shift0;
  logic [CntW-1:0]      col_inc;
  logic signed [SW-1:0] col_s;
  logic signed [SW-1:0] shift_s;
  logic signed [SW-1:0] left_s;
  logic signed [SW-1:0] right_s;
  logic signed [SW-1:0] width_s;
  logic [ROW_CNT_W-1:0] row0_inc;
  logic [ROW_CNT_W-1:0] row_q_inc;

  // A width of zero acts as one, and one above the buffer depth as the depth.
  always_comb begin
    if (row_width_i == '0) begin
      width = CntW'(1);
    end else if (32'(row_width_i) > 32'(MAX_WIDTH)) begin
      width = CntW'(MAX_WIDTH);
    end else begin
      width = CntW'(row_width_i);
    end
  end

  assign row_q_inc = (32'(row_q) < 32'(ROW_CAP)) ? row_q + 1'b1 : row_q;

  // Row bookkeeping before the pixel is placed: restart or close a row whose
  // width was lowered under it.
  always_comb begin
    if (frame_start_i) begin
      col0 = '0;
      row0 = '0;
      sel0 = sel_q;
    end else if (CntW'(col_q) >= width) begin
      col0 = '0;
      row0 = row_q_inc;
      sel0 = ~sel_q;
    end else begin
      col0 = col_q;
      row0 = row_q;
      sel0 = sel_q;
    end
  end

  // The jitter pattern for -2 saturates to -1.
  always_comb begin
    if (col0 == '0) begin
      case (row_shift_i)
        2'b01:   shift0 = 2'sd1;
        2'b00:   shift0 = 2'sd0;
        default: shift0 = -2'sd1;
      endcase
    end else begin
      shift0 = shift_q;
    end
  end

  assign col_s   = $signed(SW'(col0));
  assign shift_s = SW'(shift0);
  assign width_s = $signed(SW'(width));
  assign left_s  = col_s + shift_s - SW'(1);
  assign right_s = col_s + shift_s + SW'(1);

  assign col_inc  = CntW'(col0) + CntW'(1);
  assign row0_inc = (32'(row0) < 32'(ROW_CAP)) ? row0 + 1'b1 : row0;

  // Bank A takes the current row when the select is low.
  assign we_a_o    = accept_i & ~sel0;
  assign we_b_o    = accept_i &  sel0;
  assign re_a_o    = accept_i &  sel0;
  assign re_b_o    = accept_i & ~sel0;
  assign waddr_o   = col0;
  assign raddr_l_o = left_s[AW-1:0];
  assign raddr_r_o = right_s[AW-1:0];

  always_comb begin
    pix_o.emit     = (row0 >= ROW_CNT_W'(2));
    pix_o.prev_b   = ~sel0;
    pix_o.left_ok  = (left_s >= 0) && (left_s < width_s);
    pix_o.right_ok = (right_s >= 0) && (right_s < width_s);
    pix_o.heat     = heat_i;
    pix_o.column   = COL_W'(col0);
    pix_o.row      = ROW_W'(row0 - ROW_CNT_W'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      sel_q   <= 1'b0;
      shift_q <= '0;
    end else if (accept_i) begin
      shift_q <= shift0;
      if (col_inc >= width) begin
        col_q <= '0;
        row_q <= row0_inc;
        sel_q <= ~sel0;
      end else begin
        col_q <= col_inc[AW-1:0];
        row_q <= row0;
        sel_q <= sel0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/fhds_stencil.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhds_stencil
// Weighted three-tap average with decay, and the output register.
// ----------------------------------------------------------------------------
module fhds_stencil (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire fhds_pkg::pix_ctrl_t         pix_i,
  input  wire logic [fhds_pkg::HEAT_W-1:0] decay_i,
  input  wire logic [fhds_pkg::HEAT_W-1:0] a_l_i,
  input  wire logic [fhds_pkg::HEAT_W-1:0] a_r_i,
  input  wire logic [fhds_pkg::HEAT_W-1:0] b_l_i,
  input  wire logic [fhds_pkg::HEAT_W-1:0] b_r_i,
  output      logic                        in_ready_o,
  input  wire logic                        out_ready_i,
  output      logic                        out_valid_o,
  output      logic [fhds_pkg::HEAT_W-1:0] heat_o,
  output      logic [fhds_pkg::COL_W-1:0]  column_o,
  output      logic [fhds_pkg::ROW_W-1:0]  row_o
);
  import fhds_pkg::*;

  pix_ctrl_t         s1_q;
  logic              s1_valid_q;
  logic              out_valid_q;
  logic              s1_adv;
  logic [HEAT_W-1:0] left;
  logic [HEAT_W-1:0] right;
  logic [HEAT_W+1:0] total;
  logic [HEAT_W-1:0] avg;
  logic [HEAT_W-1:0] heat_d;

  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_adv;

  // Neighbors off the row read as zero.
  assign left  = !s1_q.left_ok  ? '0 : (s1_q.prev_b ? b_l_i : a_l_i);
  assign right = !s1_q.right_ok ? '0 : (s1_q.prev_b ? b_r_i : a_r_i);
  assign total = (HEAT_W+2)'(left) + (HEAT_W+2)'(right) + {1'b0, s1_q.heat, 1'b0};
  assign avg   = total[HEAT_W+1:2];
  assign heat_d = (avg > decay_i) ? avg - decay_i : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_q.emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q <= pix_i;
    end
    if (s1_adv && s1_q.emit) begin
      heat_o   <= heat_d;
      column_o <= s1_q.column;
      row_o    <= s1_q.row;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

>>> rtl/fire_heat_diffusion_stencil_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fire_heat_diffusion_stencil_unit
// Fire effect heat diffusion: streams the old heat frame in raster order and
// produces each new pixel from a jittered three-tap stencil over two rows.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Word
//  -------  ---------  -----------------  ----------------------------------
//  in_i     sink       valid / ready      heat_in, frame_start, row_shift
//  out_o    source     valid / ready      heat_out, out_column, out_row
//  APB      slave      psel / penable     row_width (0x0), decay (0x4)
//
//  One word is taken per clock while the output is not stalled. A result is
//  held in the read stage register and then loaded into the output register,
//  from which out_o hands it over. Reset clears the counters, bank select,
//  held jitter and pipeline valid flags and loads the register defaults; the
//  line buffers need no clearing pass. When the output is stalled, one word
//  more is absorbed in the read stage before in_i.ready drops.
//
//  The two bank memories alternate roles per row: the bank holding the
//  current row is written at the current column, while the other bank, which
//  holds the previous row, is read at the left and right neighbor columns.
//  Since a row is always written into the opposite bank from the one read,
//  and every write lands before the next word's read, no forwarding is
//  needed.
// ----------------------------------------------------------------------------
module fire_heat_diffusion_stencil_unit #(
  parameter int MAX_WIDTH = fhds_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  fhds_in_if.sink                            in_i,
  fhds_out_if.source                         out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fhds_pkg::APB_AW-1:0]   paddr,
  input  wire logic [fhds_pkg::APB_DW-1:0]   pwdata,
  output      logic [fhds_pkg::APB_DW-1:0]   prdata,
  output      logic                          pready
);
  import fhds_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic [HEAT_W-1:0] row_width_q;
  logic [HEAT_W-1:0] decay_q;
  reg_idx_e          reg_idx;
  logic              cfg_wr;

  logic              accept;
  logic              in_ready;
  pix_ctrl_t         pix;
  logic              we_a;
  logic              we_b;
  logic              re_a;
  logic              re_b;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr_l;
  logic [AW-1:0]     raddr_r;
  logic [HEAT_W-1:0] a_l;
  logic [HEAT_W-1:0] a_r;
  logic [HEAT_W-1:0] b_l;
  logic [HEAT_W-1:0] b_r;

  // Configuration registers. Registers sit at word addresses, so the index is
  // the address bit above the byte offset.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RST;
      decay_q     <= DECAY_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ROW_WIDTH: row_width_q <= pwdata[HEAT_W-1:0];
        REG_DECAY:     decay_q     <= pwdata[HEAT_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROW_WIDTH: prdata = APB_DW'(row_width_q);
      REG_DECAY:     prdata = APB_DW'(decay_q);
      default:       prdata = '0;
    endcase
  end

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid & in_ready;

  fhds_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .heat_i        (in_i.heat_in),
    .frame_start_i (in_i.frame_start),
    .row_shift_i   (in_i.row_shift),
    .row_width_i   (row_width_q),
    .we_a_o        (we_a),
    .we_b_o        (we_b),
    .re_a_o        (re_a),
    .re_b_o        (re_b),
    .waddr_o       (waddr),
    .raddr_l_o     (raddr_l),
    .raddr_r_o     (raddr_r),
    .pix_o         (pix)
  );

  fhds_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (HEAT_W)
  ) u_bank_a (
    .clk_i     (clk_i),
    .we_i      (we_a),
    .waddr_i   (waddr),
    .wdata_i   (in_i.heat_in),
    .re_i      (re_a),
    .raddr_l_i (raddr_l),
    .raddr_r_i (raddr_r),
    .rdata_l_o (a_l),
    .rdata_r_o (a_r)
  );

  fhds_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (HEAT_W)
  ) u_bank_b (
    .clk_i     (clk_i),
    .we_i      (we_b),
    .waddr_i   (waddr),
    .wdata_i   (in_i.heat_in),
    .re_i      (re_b),
    .raddr_l_i (raddr_l),
    .raddr_r_i (raddr_r),
    .rdata_l_o (b_l),
    .rdata_r_o (b_r)
  );

  fhds_stencil u_stencil (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .pix_i       (pix),
    .decay_i     (decay_q),
    .a_l_i       (a_l),
    .a_r_i       (a_r),
    .b_l_i       (b_l),
    .b_r_i       (b_r),
    .in_ready_o  (in_ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .heat_o      (out_o.heat_out),
    .column_o    (out_o.out_column),
    .row_o       (out_o.out_row)
  );

endmodule
`default_nettype wire

>>> bench/fire_heat_diffusion_stencil_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fire_heat_diffusion_stencil_unit_tb
// Self-checking bench for the fire heat diffusion stencil. Old heat pixels are
// streamed in raster order through the input channel with random gaps. Every
// accepted word is run through a behavioral copy of the stencil, and each new
// pixel the block returns is compared field by field against it.
// ----------------------------------------------------------------------------
module fire_heat_diffusion_stencil_unit_tb;
  import fhds_pkg::*;

  localparam int MAX_W       = MAX_WIDTH_DEF;
  // Margin for the pipe to drain once the last result is back.
  localparam int PIPE_DRAIN  = 8;
  // Cycles without any handshake on either channel or the register port before the run is declared hung.
  localparam int QUIET_LIMIT = 5000;
  // The one long output stall, and the result count at which it starts.
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AT     = 400;
  localparam int MAX_REPORTS = 20;

  // Row jitter codes as they appear on row_shift.
  localparam logic [1:0] JIT_ZERO  = 2'b00;
  localparam logic [1:0] JIT_RIGHT = 2'b01;
  localparam logic [1:0] JIT_LEFT2 = 2'b10;
  localparam logic [1:0] JIT_LEFT  = 2'b11;

  // Directed frame, four pixels per row: two bright rows to fill the line
  // buffers, then rows that mix extremes with every jitter code.
  localparam logic [20*HEAT_W-1:0] DIR_HEAT = {
    8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd0,   8'd255, 8'd255,
    8'd0,   8'd255, 8'd128, 8'd1,
    8'd16,  8'd32,  8'd64,  8'd128
  };
  localparam logic [9:0] DIR_JIT = {JIT_RIGHT, JIT_ZERO, JIT_LEFT, JIT_LEFT2, JIT_RIGHT};

  typedef struct {
    logic [HEAT_W-1:0] heat;
    logic              start;
    logic [1:0]        jitter;
    bit                drain_first;  // hold this word until all results are in
  } old_pixel_t;

  typedef struct {
    logic [HEAT_W-1:0] heat;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
  } new_pixel_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  fhds_in_if  in_if();
  fhds_out_if out_if();

  fire_heat_diffusion_stencil_unit #(
    .MAX_WIDTH(MAX_W)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Every input of the block is known from time zero; the clock then runs.
  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_if.valid        = 1'b0;
    in_if.heat_in      = '0;
    in_if.frame_start  = 1'b0;
    in_if.row_shift    = '0;
    out_if.ready       = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Stencil predictor. It mirrors the block's state: two line buffers that
  // swap roles at each row end, the column and row counters, and the jitter
  // latched at column zero. The register shadows are updated by cfg_write.
  // --------------------------------------------------------------------------
  logic [HEAT_W-1:0] bank_a [MAX_W];
  logic [HEAT_W-1:0] bank_b [MAX_W];
  logic              writing_b  = 1'b0;
  int unsigned       col_pos    = 0;
  int unsigned       rows_in    = 0;
  int                jitter_now = 0;
  logic [7:0]        width_reg  = ROW_WIDTH_RST;
  logic [7:0]        decay_reg  = DECAY_RST;

  old_pixel_t  pixels_to_send[$];
  new_pixel_t  heat_due[$];

  int unsigned words_queued   = 0;
  int unsigned words_in       = 0;
  int unsigned words_out      = 0;
  int unsigned errors         = 0;
  int unsigned phases_run     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned tx_idle_left   = 0;
  int unsigned rx_hold_left   = 0;
  bit          tx_calm        = 1'b0;
  bit          rx_calm        = 1'b0;
  bit          long_hold_done = 1'b0;

  // A width of zero behaves as one, and anything past the buffer depth is
  // clipped to it.
  function automatic int unsigned eff_width(input logic [7:0] w);
    if (w == 8'd0) return 1;
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  // Neighbor from the previous row; columns off the row read as zero.
  function automatic int unsigned prev_tap(input int c, input int unsigned w);
    if (c < 0 || c >= int'(w)) return 0;
    return writing_b ? bank_a[c] : bank_b[c];
  endfunction

  task automatic close_row();
    col_pos = 0;
    if (rows_in < ROW_CAP) rows_in++;
    writing_b = ~writing_b;
  endtask

  task automatic diffuse_pixel(input logic [HEAT_W-1:0] heat, input logic start,
                               input logic [1:0] jit);
    int unsigned w;
    int unsigned total;
    int          x;
    new_pixel_t  px;
    w = eff_width(width_reg);
    // A frame start restarts the counters but leaves the buffers alone. If the
    // width was lowered below the current column, the row is closed first.
    if (start) begin
      col_pos = 0;
      rows_in = 0;
    end else if (col_pos >= w) begin
      close_row();
    end
    if (col_pos == 0) begin
      case (jit)
        JIT_ZERO:  jitter_now = 0;
        JIT_RIGHT: jitter_now = 1;
        default:   jitter_now = -1;  // the minus-two pattern saturates to minus one
      endcase
    end
    x = int'(col_pos);
    if (rows_in >= 2) begin
      total = (prev_tap(x - 1 + jitter_now, w) + prev_tap(x + 1 + jitter_now, w)
               + 2 * int'(heat)) >> 2;
      px.heat   = (total > decay_reg) ? HEAT_W'(total - decay_reg) : '0;
      px.column = COL_W'(col_pos);
      px.row    = (rows_in - 2 > 255) ? 8'd255 : ROW_W'(rows_in - 2);
      heat_due.push_back(px);
    end
    if (writing_b) bank_b[col_pos] = heat;
    else bank_a[col_pos] = heat;
    col_pos++;
    if (col_pos >= w) close_row();
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Mostly short gaps, now and then a long one; none at all in calm stretches.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard. Predictions are made from the word the block actually took,
  // and the check runs in the same block so a prediction is always queued
  // before its result can be popped.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    new_pixel_t due;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        diffuse_pixel(in_if.heat_in, in_if.frame_start, in_if.row_shift);
        words_in++;
      end
      if (out_if.valid && out_if.ready) begin
        words_out++;
        if (heat_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word heat %0d column %0d row %0d",
                                    out_if.heat_out, out_if.out_column, out_if.out_row));
        end else begin
          due = heat_due.pop_front();
          if (out_if.heat_out !== due.heat)
            report_mismatch($sformatf("heat_out %0d, expected %0d at column %0d row %0d",
                                      out_if.heat_out, due.heat, due.column, due.row));
          if (out_if.out_column !== due.column)
            report_mismatch($sformatf("out_column %0d, expected %0d",
                                      out_if.out_column, due.column));
          if (out_if.out_row !== due.row)
            report_mismatch($sformatf("out_row %0d, expected %0d", out_if.out_row, due.row));
        end
      end
    end
  end

  // Input driver: a new word goes out only when the previous one was taken or
  // none was offered. A word marked drain_first waits until every result is
  // back; the extra check on valid lets the last result's prediction land.
  always @(posedge clk_i) begin
    old_pixel_t w;
    if (rst_ni) begin
      if (!in_if.valid || in_if.ready) begin
        if (tx_idle_left != 0) begin
          in_if.valid  <= 1'b0;
          tx_idle_left <= tx_idle_left - 1;
        end else if (pixels_to_send.size() != 0 &&
                     !(pixels_to_send[0].drain_first &&
                       (heat_due.size() != 0 || in_if.valid))) begin
          w = pixels_to_send.pop_front();
          in_if.valid       <= 1'b1;
          in_if.heat_in     <= w.heat;
          in_if.frame_start <= w.start;
          in_if.row_shift   <= w.jitter;
          tx_idle_left      <= pick_gap(tx_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 255) == 0) tx_calm <= ~tx_calm;
    end
  end

  // Output receiver: random stalls after results, plus one long hold-off that
  // lets the pipe fill up and push back on the input channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && words_out >= HOLD_AT) begin
        long_hold_done <= 1'b1;
        out_if.ready   <= 1'b0;
        rx_hold_left   <= LONG_HOLD;
      end else if (rx_hold_left != 0) begin
        out_if.ready <= 1'b0;
        rx_hold_left <= rx_hold_left - 1;
      end else begin
        out_if.ready <= 1'b1;
        if (out_if.valid && out_if.ready) rx_hold_left <= pick_gap(rx_calm);
      end
      if ($urandom_range(0, 255) == 0) rx_calm <= ~rx_calm;
    end
  end

  // Watchdog: any handshake on either channel or the register port counts as
  // progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, heat_due.size());
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Register write: setup cycle, then access cycle; the register takes the
  // value at the edge that ends the access cycle.
  task automatic cfg_write(input reg_idx_e idx, input logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(int'(idx) * 4);
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ROW_WIDTH) width_reg = value;
    else decay_reg = value;
  endtask

  task automatic queue_pixel(input logic [HEAT_W-1:0] heat, input logic start,
                             input logic [1:0] jit, input bit drain_first);
    old_pixel_t w;
    w.heat        = heat;
    w.start       = start;
    w.jitter      = jit;
    w.drain_first = drain_first;
    pixels_to_send.push_back(w);
    words_queued++;
  endtask

  // Idle means every queued word was accepted and every result came back.
  // Words that produce nothing may still be in flight, hence the drain wait.
  task automatic wait_drained();
    while (words_in != words_queued || heat_due.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  // One setting of width and decay followed by a run of random pixels. When
  // the width grows, the buffers hold rows that are too short, so the phase
  // opens a new frame; a shrinking width is left to cut the current row.
  task automatic run_phase(input logic [7:0] width, input logic [7:0] decay,
                           input int unsigned n, input bit fresh_frame,
                           input bit noisy, input bit with_pause);
    bit                raised;
    logic [HEAT_W-1:0] h;
    wait_drained();
    raised = eff_width(width) > eff_width(width_reg);
    cfg_write(REG_ROW_WIDTH, width);
    cfg_write(REG_DECAY, decay);
    phases_run++;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0:       h = '0;
        1:       h = '1;
        default: h = HEAT_W'($urandom);
      endcase
      queue_pixel(h, (i == 0 && (fresh_frame || raised)) ||
                     (noisy && $urandom_range(0, 149) == 0),
                  2'($urandom), with_pause && i == n / 2);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frame at width 4 with no decay: bright rows, every jitter
    // code, and neighbors falling off both ends of the row.
    run_phase(8'd4, 8'd0, 0, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < 20; i++) begin
      queue_pixel(DIR_HEAT[HEAT_W*(19-i) +: HEAT_W], i == 0,
                  (i % 4 == 0) ? DIR_JIT[2*(4-i/4) +: 2] : JIT_ZERO, 1'b0);
    end
    // A frame start in the middle of a row.
    queue_pixel(8'h5A, 1'b0, JIT_LEFT, 1'b0);
    queue_pixel(8'hA5, 1'b1, JIT_LEFT2, 1'b0);
    queue_pixel(8'h0F, 1'b0, JIT_RIGHT, 1'b0);

    // Narrow rows and one long frame, so the row count saturates.
    run_phase(8'd3, 8'd1, 790, 1'b1, 1'b0, 1'b0);
    // Width zero acts as one; a full decay clamps every result to zero.
    run_phase(8'd0, 8'd255, 60, 1'b0, 1'b1, 1'b0);
    run_phase(8'd1, 8'd0, 60, 1'b0, 1'b1, 1'b0);
    // Width two, with a pause on the input side until all results are in.
    run_phase(8'd2, 8'd7, 80, 1'b0, 1'b1, 1'b1);
    // Full width, then widths past the buffer depth that clip to it.
    run_phase(8'd128, 8'($urandom), 400, 1'b0, 1'b0, 1'b0);
    run_phase(8'd255, 8'($urandom), 300, 1'b0, 1'b0, 1'b0);
    run_phase(8'd200, 8'($urandom), 100, 1'b0, 1'b0, 1'b0);
    // The previous phase ends deep in a row; a narrow width cuts it short.
    run_phase(8'($urandom_range(3, 8)), 8'($urandom), 120, 1'b0, 1'b1, 1'b0);
    run_phase(8'($urandom_range(3, 128)), 8'($urandom), 120, 1'b0, 1'b1, 1'b0);
    run_phase(8'($urandom_range(3, 128)), 8'($urandom), 120, 1'b0, 1'b1, 1'b1);
    run_phase(8'd5, 8'd10, 100, 1'b0, 1'b1, 1'b0);
    wait_drained();

    $display("Sent %0d old pixels and checked %0d new pixels across %0d width/decay settings,",
             words_in, words_out, phases_run);
    $display("with a %0d-cycle output stall, an input pause and row count saturation.",
             LONG_HOLD);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
